/* hw/rtl/chxy_pkg.sv */
// package for the compass heading unit: widths, constants, state type and the
// arctangent table used by the cordic sequencer
// no dependencies
package chxy_pkg;

  localparam int unsigned SAMPLE_BITS  = 16;
  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned STEP_W       = $clog2(CORDIC_STEPS);
  localparam int unsigned ATAN_ENTRIES = 24;
  localparam int unsigned ATAN_IDX_W   = $clog2(ATAN_ENTRIES);

  // samples are scaled up to 30 bits, plus headroom for negation and cordic gain
  localparam int unsigned SCALE_SHIFT  = 30 - SAMPLE_BITS;
  localparam int unsigned DAT_W        = 33;
  localparam int unsigned ACC_W        = 32;
  localparam int unsigned TURN_W       = 16;
  localparam int unsigned DEG_W        = 9;
  localparam int unsigned DEG_PER_TURN = 360;

  // declination: arcminutes to 2^-32 turn, rounded half away from zero
  // 2^32 = 21600 * 198841 + 1696, so round(m * 2^32 / 21600) equals
  // m * 198841 + floor((53 * m + 337) / 675), the last part by reciprocal
  // multiply: floor(v / 675) = (v * 1590729) >> 30 for v below 2^20
  localparam int unsigned DECL_W        = 15;
  localparam int unsigned DECL_RESET    = 38;
  localparam int unsigned DECL_QUO      = 198841;
  localparam int unsigned DECL_QUO_W    = 18;
  localparam int unsigned DECL_FRAC_MUL = 53;
  localparam int unsigned DECL_FRAC_ADD = 337;
  localparam int unsigned DECL_FRAC_W   = 20;
  localparam int unsigned DECL_RECIP    = 1590729;
  localparam int unsigned DECL_RECIP_W  = 21;
  localparam int unsigned DECL_RECIP_SH = 30;
  localparam int unsigned DECL_LO_W     = 11;

  localparam logic [ACC_W-1:0] HALF_TURN = ACC_W'(32'h8000_0000);
  localparam logic [ACC_W-1:0] ROUND_BIAS = ACC_W'(32'h0000_8000);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECL_MUL,
    ST_DECL_RECIP,
    ST_DECL_SUM,
    ST_ROTATE,
    ST_ROUND,
    ST_DEGREE
  } state_e;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [ACC_W-1:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
    logic [ACC_W-1:0] v;
    case (idx)
      5'd0:    v = 32'h2000_0000;
      5'd1:    v = 32'h12E4_051E;
      5'd2:    v = 32'h09FB_385B;
      5'd3:    v = 32'h0511_11D4;
      5'd4:    v = 32'h028B_0D43;
      5'd5:    v = 32'h0145_D7E1;
      5'd6:    v = 32'h00A2_F61E;
      5'd7:    v = 32'h0051_7C55;
      5'd8:    v = 32'h0028_BE53;
      5'd9:    v = 32'h0014_5F2F;
      5'd10:   v = 32'h000A_2F98;
      5'd11:   v = 32'h0005_17CC;
      5'd12:   v = 32'h0002_8BE6;
      5'd13:   v = 32'h0001_45F3;
      5'd14:   v = 32'h0000_A2F9;
      5'd15:   v = 32'h0000_517C;
      5'd16:   v = 32'h0000_28BE;
      5'd17:   v = 32'h0000_145F;
      5'd18:   v = 32'h0000_0A2F;
      5'd19:   v = 32'h0000_0517;
      5'd20:   v = 32'h0000_028B;
      5'd21:   v = 32'h0000_0145;
      5'd22:   v = 32'h0000_00A2;
      5'd23:   v = 32'h0000_0051;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* hw/rtl/compass_heading_from_xy_unit.sv */
// compass heading unit: vectoring cordic atan2 on an x/y sample, declination
// add, rounding to 1/65536 turn, floored to whole degrees, reported on change only
// depends on chxy_pkg
//
//   channel  direction  handshake              payload
//   in       sink       in_valid_i / in_stall_o    x_sample_i, y_sample_i
//   out      source     out_valid_o / out_stall_i  heading_deg_o, heading_turn_o
//   cfg      sink       cfg_valid_i / cfg_ready_o  declination_arcmin_i
//
// an input word is taken in an idle cycle and then holds the unit through 16
// cordic steps on the one shift/add rotator, a rounding step and the
// degree/compare step, which writes a changed result into the output register
// a declination write runs through the whole-turn multiply, the reciprocal
// multiply for the remainder part, and the sum and sign; input and config
// are held off meanwhile; after reset the same update runs on the reset
// declination; a result waits in the output register; a new result waits in
// the degree step while the previous one is still stalled
module compass_heading_from_xy_unit
  import chxy_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [15:0]        x_sample_i,
  input  logic signed [15:0]        y_sample_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [8:0]                heading_deg_o,
  output logic [15:0]               heading_turn_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic signed [DECL_W-1:0]  declination_arcmin_i
);

  state_e                  state_q, state_d;
  logic [STEP_W-1:0]       step_q, step_d;
  logic [DECL_W-1:0]       decl_mag_q, decl_mag_d;
  logic [ACC_W-1:0]        decl_hi_q, decl_hi_d;
  logic [DECL_FRAC_W-1:0]  decl_frac_q, decl_frac_d;
  logic [DECL_LO_W-1:0]    decl_lo_q, decl_lo_d;
  logic                    decl_neg_q, decl_neg_d;
  logic [ACC_W-1:0]        decl_turn_q, decl_turn_d;
  logic signed [DAT_W-1:0] x_q, x_d, y_q, y_d;
  logic [ACC_W-1:0]        acc_q, acc_d;
  logic                    zero_q, zero_d;
  logic [TURN_W-1:0]       turn_q, turn_d;
  logic [DEG_W-1:0]        last_deg_q, last_deg_d;
  logic                    out_valid_q, out_valid_d;
  logic [DEG_W-1:0]        out_deg_q, out_deg_d;
  logic [TURN_W-1:0]       out_turn_q, out_turn_d;

  // declination update signals
  logic [DECL_W-1:0]                    decl_mag;
  logic [DECL_W+DECL_QUO_W-1:0]         hi_prod;
  logic [DECL_FRAC_W-1:0]               frac_val;
  logic [DECL_FRAC_W+DECL_RECIP_W-1:0]  recip_prod;
  logic [ACC_W-1:0]                     decl_sum;

  // rotator signals
  logic signed [DAT_W-1:0] xs, ys, x_ld, y_ld;
  logic [ACC_W-1:0]        atan_val, angle_eff, angle_sum;

  // degree signals
  logic [TURN_W+DEG_W-1:0] deg_prod;
  logic [DEG_W-1:0]        deg_new;

  logic in_take, cfg_take;

  assign cfg_ready_o = (state_q == ST_IDLE);
  assign cfg_take    = cfg_valid_i && cfg_ready_o;
  // a config write wins over an input word in the same cycle
  assign in_stall_o  = (state_q != ST_IDLE) || cfg_valid_i;
  assign in_take     = in_valid_i && !in_stall_o;

  assign out_valid_o    = out_valid_q;
  assign heading_deg_o  = out_deg_q;
  assign heading_turn_o = out_turn_q;

  // |d| of the written declination
  assign decl_mag = declination_arcmin_i[DECL_W-1] ? DECL_W'(-declination_arcmin_i)
                                                   : DECL_W'(declination_arcmin_i);

  // whole-turn part and remainder numerator, then floor by reciprocal
  assign hi_prod    = (DECL_W+DECL_QUO_W)'(decl_mag_q) * (DECL_W+DECL_QUO_W)'(DECL_QUO);
  assign frac_val   = DECL_FRAC_W'(decl_mag_q) * DECL_FRAC_W'(DECL_FRAC_MUL)
                    + DECL_FRAC_W'(DECL_FRAC_ADD);
  assign recip_prod = (DECL_FRAC_W+DECL_RECIP_W)'(decl_frac_q)
                    * (DECL_FRAC_W+DECL_RECIP_W)'(DECL_RECIP);
  assign decl_sum   = decl_hi_q + ACC_W'(decl_lo_q);

  // shared rotator: arithmetic shift floors toward minus infinity
  assign xs       = x_q >>> step_q;
  assign ys       = y_q >>> step_q;
  assign atan_val = atan_turn(ATAN_IDX_W'(step_q));

  // sample load with scaling to 30 bits
  assign x_ld = DAT_W'(x_sample_i) <<< SCALE_SHIFT;
  assign y_ld = DAT_W'(y_sample_i) <<< SCALE_SHIFT;

  // zero vector gives a raw angle of zero
  assign angle_eff = zero_q ? '0 : acc_q;
  assign angle_sum = angle_eff + decl_turn_q + ROUND_BIAS;

  assign deg_prod = (TURN_W+DEG_W)'(turn_q) * (TURN_W+DEG_W)'(DEG_PER_TURN);
  assign deg_new  = deg_prod[TURN_W+DEG_W-1:TURN_W];

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    decl_mag_d  = decl_mag_q;
    decl_hi_d   = decl_hi_q;
    decl_frac_d = decl_frac_q;
    decl_lo_d   = decl_lo_q;
    decl_neg_d  = decl_neg_q;
    decl_turn_d = decl_turn_q;
    x_d         = x_q;
    y_d         = y_q;
    acc_d       = acc_q;
    zero_d      = zero_q;
    turn_d      = turn_q;
    last_deg_d  = last_deg_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_deg_d   = out_deg_q;
    out_turn_d  = out_turn_q;

    unique case (state_q)
      ST_IDLE: begin
        if (cfg_take) begin
          decl_mag_d = decl_mag;
          decl_neg_d = declination_arcmin_i[DECL_W-1];
          state_d    = ST_DECL_MUL;
        end else if (in_take) begin
          zero_d = (x_sample_i == '0) && (y_sample_i == '0);
          step_d = '0;
          // left half plane: rotate by half a turn first
          if (x_sample_i[15]) begin
            x_d   = -x_ld;
            y_d   = -y_ld;
            acc_d = HALF_TURN;
          end else begin
            x_d   = x_ld;
            y_d   = y_ld;
            acc_d = '0;
          end
          state_d = ST_ROTATE;
        end
      end
      ST_DECL_MUL: begin
        decl_hi_d   = hi_prod[ACC_W-1:0];
        decl_frac_d = frac_val;
        state_d     = ST_DECL_RECIP;
      end
      ST_DECL_RECIP: begin
        decl_lo_d = recip_prod[DECL_RECIP_SH +: DECL_LO_W];
        state_d   = ST_DECL_SUM;
      end
      ST_DECL_SUM: begin
        decl_turn_d = decl_neg_q ? (ACC_W'(0) - decl_sum) : decl_sum;
        state_d     = ST_IDLE;
      end
      ST_ROTATE: begin
        if (!y_q[DAT_W-1]) begin
          x_d   = x_q + ys;
          y_d   = y_q - xs;
          acc_d = acc_q + atan_val;
        end else begin
          x_d   = x_q - ys;
          y_d   = y_q + xs;
          acc_d = acc_q - atan_val;
        end
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(CORDIC_STEPS - 1)) begin
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        turn_d  = angle_sum[ACC_W-1 -: TURN_W];
        state_d = ST_DEGREE;
      end
      ST_DEGREE: begin
        if (deg_new == last_deg_q) begin
          state_d = ST_IDLE;
        end else if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_deg_d   = deg_new;
          out_turn_d  = turn_q;
          last_deg_d  = deg_new;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      // reset starts the declination update on the reset value
      state_q     <= ST_DECL_MUL;
      step_q      <= '0;
      decl_mag_q  <= DECL_W'(DECL_RESET);
      decl_hi_q   <= '0;
      decl_frac_q <= '0;
      decl_lo_q   <= '0;
      decl_neg_q  <= 1'b0;
      decl_turn_q <= '0;
      last_deg_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      decl_mag_q  <= decl_mag_d;
      decl_hi_q   <= decl_hi_d;
      decl_frac_q <= decl_frac_d;
      decl_lo_q   <= decl_lo_d;
      decl_neg_q  <= decl_neg_d;
      decl_turn_q <= decl_turn_d;
      last_deg_q  <= last_deg_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath words, no reset needed
  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    y_q        <= y_d;
    acc_q      <= acc_d;
    zero_q     <= zero_d;
    turn_q     <= turn_d;
    out_deg_q  <= out_deg_d;
    out_turn_q <= out_turn_d;
  end

endmodule

/* hw/rtl/chxy_checker.sv */
// port-level checks for the compass heading unit, bound to the top level
// depends on chxy_pkg and compass_heading_from_xy_unit
module chxy_checker
  import chxy_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_stall_o,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic [8:0]               heading_deg_o,
  input logic [15:0]              heading_turn_o,
  input logic                     cfg_valid_i,
  input logic                     cfg_ready_o
);

  logic [TURN_W+DEG_W-1:0] chk_prod;
  assign chk_prod = (TURN_W+DEG_W)'(heading_turn_o) * (TURN_W+DEG_W)'(DEG_PER_TURN);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(heading_deg_o)
      && $stable(heading_turn_o))
    else $error("result word changed while stalled");

  a_deg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> heading_deg_o < DEG_W'(DEG_PER_TURN))
    else $error("degree out of range");

  a_deg_turn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> heading_deg_o == chk_prod[TURN_W+DEG_W-1:TURN_W])
    else $error("degree does not match turn");

  // the cordic keeps the unit busy after a word is taken
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o && !cfg_ready_o)
    else $error("input not held off during cordic");

  // the declination update keeps the unit busy after a config write
  a_busy_after_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |=> in_stall_o && !cfg_ready_o)
    else $error("unit not busy after declination write");

endmodule

bind compass_heading_from_xy_unit chxy_checker u_chxy_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .heading_deg_o  (heading_deg_o),
  .heading_turn_o (heading_turn_o),
  .cfg_valid_i    (cfg_valid_i),
  .cfg_ready_o    (cfg_ready_o)
);
